// ===== sv/kth_remaining_select_remove_assert.svh =====
// Assertion macros used by the block's RTL
`ifndef KTH_REMAINING_SELECT_REMOVE_ASSERT_SVH
`define KTH_REMAINING_SELECT_REMOVE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define KSR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define KSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ksr_pkg.sv =====
package ksr_pkg;

  // Default number of slots in the store
  localparam int CAPACITY_DEFAULT = 1024;

  // Fixed field widths of the channels
  localparam int VALUE_W = 32;
  localparam int RANK_W  = 11;
  localparam int SLOT_W  = 10;
  localparam int REM_W   = 11;

  // Item kinds
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_RANK_ERR = 2'd1,
    STATUS_FULL     = 2'd2
  } status_t;

endpackage

// ===== sv/ksr_in_if.sv =====
interface ksr_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [ksr_pkg::VALUE_W-1:0] load_value;
  logic [ksr_pkg::RANK_W-1:0]  rank;

  modport source (output valid, output kind, output load_value, output rank, input ready);
  modport sink   (input valid, input kind, input load_value, input rank, output ready);
endinterface

// ===== sv/ksr_out_if.sv =====
interface ksr_out_if;
  logic                        valid;
  logic                        ready;
  logic [ksr_pkg::VALUE_W-1:0] removed_value;
  logic [ksr_pkg::SLOT_W-1:0]  removed_slot;
  logic [1:0]                  status;
  logic [ksr_pkg::REM_W-1:0]   remaining;

  modport source (output valid, output removed_value, output removed_slot, output status,
                  output remaining, input ready);
  modport sink   (input valid, input removed_value, input removed_slot, input status,
                  input remaining, output ready);
endinterface

// ===== sv/kth_remaining_select_remove.sv =====
// Order-statistic store: load appends a value, remove takes out the k-th present entry.
// Sequence: load climbs S_LOAD from the new leaf toward the root, remove descends in S_DESC,
//   one count-memory level per cycle, LEVELS = clog2(CAPACITY) (10 for 1024 slots);
//   errors go straight to S_DONE. A new item is taken only back in S_IDLE, once the result is registered.
// Reset: control state, load count and remaining count clear; the memories are not
//   cleared, a tree node counts as zero until a load reaches its leftmost slot.
module kth_remaining_select_remove #(
  parameter int CAPACITY = ksr_pkg::CAPACITY_DEFAULT
) (
  input logic      clk,
  input logic      rst,
  ksr_in_if.sink   items,
  ksr_out_if.source results
);

  localparam int LEVELS = $clog2(CAPACITY);
  localparam int SW     = LEVELS;
  localparam int AW     = LEVELS + 1;
  localparam int NODES  = 1 << AW;
  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int KW     = (CW > ksr_pkg::RANK_W) ? CW : ksr_pkg::RANK_W;
  localparam int RW     = (CW > ksr_pkg::REM_W) ? CW : ksr_pkg::REM_W;
  localparam int LW     = (SW > ksr_pkg::SLOT_W) ? SW : ksr_pkg::SLOT_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_DESC = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state;

  // Control registers
  logic [CW-1:0] loaded_count;
  logic [CW-1:0] remaining;
  logic          wvalid;
  logic          ov;

  // Sequencer working registers
  logic [AW-1:0] node;
  logic [AW-1:0] wnode;
  logic          wfresh;
  logic [SW-1:0] sh;
  logic          flp;
  logic [CW-1:0] pc;
  logic [CW-1:0] k;

  // Pending result
  ksr_pkg::status_t pst;
  logic             pfrom;
  logic [SW-1:0]    pslot;

  // Output register
  logic [ksr_pkg::VALUE_W-1:0] ovalue;
  logic [ksr_pkg::SLOT_W-1:0]  oslot;
  ksr_pkg::status_t            ostat;
  logic [ksr_pkg::REM_W-1:0]   orem;

  // Memories
  logic [CW-1:0]               cmem [0:NODES-1];
  logic [CW-1:0]               cmem_q;
  logic [ksr_pkg::VALUE_W-1:0] vmem [0:CAPACITY-1];
  logic [ksr_pkg::VALUE_W-1:0] vmem_q;

  // Combinational signals
  logic          accept;
  logic          load_acc;
  logic          full;
  logic          rank_bad;
  logic [KW-1:0] rank_w;
  logic [SW-1:0] s;
  logic          fl_cur;
  logic          go_right;
  logic [AW-1:0] child;
  logic [CW-1:0] ccount;
  logic          leaf;
  logic [AW-1:0] cra;
  logic          cwe;
  logic [AW-1:0] cwa;
  logic [CW-1:0] cwd;
  logic [LW-1:0] slot_w;
  logic [RW-1:0] rem_w;
  logic          out_load;

  assign items.ready = (state == S_IDLE);
  assign accept      = items.valid && items.ready;
  assign s           = loaded_count[SW-1:0];
  assign full        = (loaded_count >= CW'(CAPACITY));
  assign load_acc    = accept && (items.kind == ksr_pkg::KIND_LOAD) && !full;
  assign rank_w      = KW'(items.rank);
  assign rank_bad    = (rank_w == '0) || (rank_w > KW'(remaining));

  // Ancestor of the new leaf is fresh when no earlier slot lies under it
  assign fl_cur = flp & ~sh[0];

  // Descent step: cmem_q holds the left child's count
  assign go_right = (k > cmem_q);
  assign child    = {node[AW-2:0], go_right};
  assign ccount   = go_right ? (pc - cmem_q) : cmem_q;
  assign leaf     = child[AW-1];

  // Output register takes a new transaction when empty or being drained
  assign out_load = (state == S_DONE) && (!ov || results.ready);

  // Count memory read address
  always_comb begin
    unique case (state)
      S_LOAD:  cra = node;
      S_DESC:  cra = {child[AW-2:0], 1'b0};
      default: cra = AW'(2);
    endcase
  end

  // Count memory write port: descent writes the chosen child, load writes one step behind
  always_comb begin
    if (state == S_DESC) begin
      cwe = 1'b1;
      cwa = child;
      cwd = ccount - CW'(1);
    end else begin
      cwe = wvalid;
      cwa = wnode;
      cwd = wfresh ? CW'(1) : (cmem_q + CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (cwe) begin
      cmem[cwa] <= cwd;
    end
    cmem_q <= cmem[cra];
  end

  // Value store
  always_ff @(posedge clk) begin
    if (load_acc) begin
      vmem[s] <= items.load_value;
    end
    if (state == S_DESC && leaf) begin
      vmem_q <= vmem[child[SW-1:0]];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      loaded_count <= '0;
      remaining    <= '0;
      wvalid       <= 1'b0;
      ov           <= 1'b0;
    end else begin
      if (out_load) begin
        ov <= 1'b1;
      end else if (results.ready) begin
        ov <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (items.valid) begin
            if (items.kind == ksr_pkg::KIND_REMOVE) begin
              if (rank_bad) begin
                pst   <= ksr_pkg::STATUS_RANK_ERR;
                pfrom <= 1'b0;
                pslot <= '0;
                state <= S_DONE;
              end else begin
                node      <= AW'(1);
                pc        <= remaining;
                k         <= rank_w[CW-1:0];
                remaining <= remaining - CW'(1);
                state     <= S_DESC;
              end
            end else if (full) begin
              pst   <= ksr_pkg::STATUS_FULL;
              pfrom <= 1'b0;
              pslot <= '0;
              state <= S_DONE;
            end else begin
              wnode        <= {1'b1, s};
              wfresh       <= 1'b1;
              wvalid       <= 1'b1;
              node         <= AW'({1'b1, s} >> 1);
              sh           <= s;
              flp          <= 1'b1;
              loaded_count <= loaded_count + CW'(1);
              remaining    <= remaining + CW'(1);
              pst          <= ksr_pkg::STATUS_OK;
              pfrom        <= 1'b0;
              pslot        <= '0;
              state        <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          // Root count lives in the remaining register
          if (node == AW'(1)) begin
            wvalid <= 1'b0;
            state  <= S_DONE;
          end else begin
            wnode  <= node;
            wfresh <= fl_cur;
            wvalid <= 1'b1;
            node   <= node >> 1;
            sh     <= sh >> 1;
            flp    <= fl_cur;
          end
        end
        S_DESC: begin
          node <= child;
          pc   <= ccount;
          if (go_right) begin
            k <= k - cmem_q;
          end
          if (leaf) begin
            pst   <= ksr_pkg::STATUS_OK;
            pfrom <= 1'b1;
            pslot <= child[SW-1:0];
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            ovalue <= pfrom ? vmem_q : '0;
            oslot  <= slot_w[ksr_pkg::SLOT_W-1:0];
            ostat  <= pst;
            orem   <= rem_w[ksr_pkg::REM_W-1:0];
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign slot_w = LW'(pslot);
  assign rem_w  = RW'(remaining);

  assign results.valid         = ov;
  assign results.removed_value = ovalue;
  assign results.removed_slot  = oslot;
  assign results.status        = ostat;
  assign results.remaining     = orem;

  // Checks
  `include "kth_remaining_select_remove_assert.svh"

  `KSR_ASSERT_NOW(a_rem_le_loaded, clk, rst, 1'b1, remaining <= loaded_count, "remaining above loaded count")
  `KSR_ASSERT_NEXT(a_load_counts, clk, rst, load_acc, loaded_count == $past(loaded_count) + CW'(1), "load count did not advance")
  `KSR_ASSERT_NOW(a_load_no_overlap, clk, rst, state == S_LOAD && wvalid && node != AW'(1), cwa != cra, "load write hits node being read")
  `KSR_ASSERT_NOW(a_desc_no_overlap, clk, rst, state == S_DESC && !leaf, cwa != cra, "descent write hits node being read")

endmodule

// ===== sim/order_stat_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels, keeps its own count tree and value store, and checks
// every result against the oldest outstanding expectation.
module order_stat_checker (
  input  logic clk,
  input  logic rst,
  ksr_in_if    items,
  ksr_out_if   results,
  output int   mismatch_count,
  output int   pending
);
  import ksr_pkg::*;

  localparam int CAP    = CAPACITY_DEFAULT;
  localparam int LEAVES = 1 << $clog2(CAP);

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [SLOT_W-1:0]  slot;
    status_t            status;
    logic [REM_W-1:0]   remaining;
  } outcome_t;

  // Predictor state: loaded values, present counts per node, slots used so far
  logic [VALUE_W-1:0] slot_values [CAP];
  int unsigned        live_count [2*LEAVES];
  int unsigned        loads_taken;
  outcome_t           expected_outcomes [$];

  // Apply one accepted transaction to the predictor, return its result
  function automatic outcome_t apply_item(logic kind, logic [VALUE_W-1:0] value,
                                          logic [RANK_W-1:0] rank);
    outcome_t    res;
    int unsigned node;
    int unsigned k;
    res        = '0;
    res.status = STATUS_OK;
    k          = rank;
    if (kind == KIND_LOAD) begin
      if (loads_taken >= CAP) begin
        res.status = STATUS_FULL;
      end else begin
        slot_values[loads_taken] = value;
        node = LEAVES + loads_taken;
        while (node >= 1) begin
          live_count[node]++;
          node = node >> 1;
        end
        loads_taken++;
      end
    end else if (k == 0 || k > live_count[1]) begin
      res.status = STATUS_RANK_ERR;
    end else begin
      // descend to the k-th present slot
      node = 1;
      while (node < LEAVES) begin
        if (k <= live_count[2*node]) begin
          node = 2*node;
        end else begin
          k    = k - live_count[2*node];
          node = 2*node + 1;
        end
      end
      res.slot  = SLOT_W'(node - LEAVES);
      res.value = slot_values[node - LEAVES];
      // clear it on the way back up
      while (node >= 1) begin
        if (live_count[node] > 0) live_count[node]--;
        node = node >> 1;
      end
    end
    res.remaining = REM_W'(live_count[1]);
    return res;
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("result field %s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatch_count++;
    end
  endfunction

  // Compare results first: a result never belongs to a transaction of the same cycle
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      foreach (live_count[i]) live_count[i] = 0;
      loads_taken = 0;
      expected_outcomes.delete();
    end else begin
      if (results.valid && results.ready) begin
        if (expected_outcomes.size() == 0) begin
          $error("result transaction with no outstanding item");
          mismatch_count++;
        end else begin
          want = expected_outcomes.pop_front();
          check_field("removed_value", want.value, results.removed_value);
          check_field("removed_slot", want.slot, results.removed_slot);
          check_field("status", want.status, results.status);
          check_field("remaining", want.remaining, results.remaining);
        end
      end
      if (items.valid && items.ready)
        expected_outcomes.insert(expected_outcomes.size(),
                                 apply_item(items.kind, items.load_value, items.rank));
    end
    pending <= expected_outcomes.size();
  end

endmodule

// ===== sim/kth_remaining_select_remove_tb.sv =====
`timescale 1ns / 1ps

module kth_remaining_select_remove_tb;
  import ksr_pkg::*;

  localparam int CAP           = CAPACITY_DEFAULT;
  localparam int RANDOM_ITEMS  = 1130;
  localparam int DRAIN_SPAN    = 80;    // items left for removals once the store is full
  localparam int STALL_LIMIT   = 4000;  // cycles with no transaction on either channel
  localparam int SETTLE_CYCLES = 20;
  localparam int RANK_MAX      = (1 << RANK_W) - 1;

  logic clk;
  logic rst;

  ksr_in_if  items_ch ();
  ksr_out_if results_ch ();

  int mismatch_count;
  int pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int stalled_cycles = 0;

  // Mirror of fill level, used to steer ranks and the fill and for the summary
  int loaded  = 0;
  int present = 0;
  int n_sent = 0, n_removed = 0, n_rank_err = 0, n_full = 0;

  kth_remaining_select_remove #(.CAPACITY(CAP)) DUT (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch)
  );

  order_stat_checker order_stat_check (
    .clk            (clk),
    .rst            (rst),
    .items          (items_ch),
    .results        (results_ch),
    .mismatch_count (mismatch_count),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    results_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on handshake activity
  always @(posedge clk) begin
    if (rst || (items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles == STALL_LIMIT) begin
      $display("kth_remaining_select_remove_tb: errors");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  // Present one transaction, with random idle cycles ahead of it
  task automatic send_item(input logic kind, input logic [VALUE_W-1:0] value,
                           input logic [RANK_W-1:0] rank);
    while ($urandom_range(99) < send_idle_pct) begin
      items_ch.valid <= 1'b0;
      @(posedge clk);
    end
    items_ch.valid      <= 1'b1;
    items_ch.kind       <= kind;
    items_ch.load_value <= value;
    items_ch.rank       <= rank;
    @(posedge clk);
    while (!items_ch.ready) @(posedge clk);
    n_sent++;
    if (kind == KIND_LOAD) begin
      if (loaded < CAP) begin
        loaded++;
        present++;
      end else begin
        n_full++;
      end
    end else if (rank >= 1 && rank <= present) begin
      present--;
      n_removed++;
    end else begin
      n_rank_err++;
    end
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(19))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly valid ranks with the ends favored, some out of range
  function automatic logic [RANK_W-1:0] pick_rank();
    int pick;
    pick = $urandom_range(99);
    if (present == 0 || pick < 10) begin
      case ($urandom_range(2))
        0: return '0;
        1: return RANK_W'(present + 1);
        default: return RANK_W'($urandom_range(RANK_MAX, present + 1));
      endcase
    end
    if (pick < 22) return RANK_W'(1);
    if (pick < 34) return RANK_W'(present);
    return RANK_W'($urandom_range(present, 1));
  endfunction

  initial begin
    logic do_load;
    items_ch.valid      = 1'b0;
    items_ch.kind       = KIND_LOAD;
    items_ch.load_value = '0;
    items_ch.rank       = '0;
    results_ch.ready    = 1'b0;
    rst                 = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty store, value extremes, bad ranks, first/middle/last removal
    send_item(KIND_REMOVE, '0, RANK_W'(1));
    send_item(KIND_REMOVE, '1, '0);
    send_item(KIND_LOAD, '0, '0);
    send_item(KIND_LOAD, '1, '1);
    send_item(KIND_LOAD, 32'hA5A5_5A5A, RANK_W'(RANK_MAX));
    send_item(KIND_LOAD, 32'h5A5A_A5A5, RANK_W'(3));
    send_item(KIND_LOAD, 32'h0000_0001, '0);
    send_item(KIND_REMOVE, '0, '0);
    send_item(KIND_REMOVE, '0, RANK_W'(6));
    send_item(KIND_REMOVE, '0, RANK_W'(RANK_MAX));
    send_item(KIND_REMOVE, '0, RANK_W'(5));
    send_item(KIND_REMOVE, '0, RANK_W'(1));
    send_item(KIND_REMOVE, '0, RANK_W'(2));
    send_item(KIND_REMOVE, '0, RANK_W'(2));
    send_item(KIND_REMOVE, '0, RANK_W'(1));
    send_item(KIND_REMOVE, '0, RANK_W'(1));
    send_item(KIND_LOAD, 32'h8000_0000, '0);
    send_item(KIND_REMOVE, '1, RANK_W'(1));

    // Random: fill toward capacity with removals mixed in, then drain on a full store
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case (i * 4 / RANDOM_ITEMS)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 76;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 76;
        end
        default: begin
          send_idle_pct  = 6;
          recv_stall_pct = 6;
        end
      endcase
      if (loaded < CAP)
        do_load = (CAP - loaded >= RANDOM_ITEMS - i - DRAIN_SPAN) || ($urandom_range(99) < 88);
      else
        do_load = ($urandom_range(99) < 20);
      if (do_load)
        send_item(KIND_LOAD, pick_value(), RANK_W'($urandom));
      else
        send_item(KIND_REMOVE, pick_value(), pick_rank());
    end
    items_ch.valid <= 1'b0;

    // Drain outstanding results, then let the block settle
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d transactions sent: %0d loads stored, %0d loads refused on a full store",
             n_sent, loaded, n_full);
    $display("%0d entries removed, %0d ranks rejected, %0d entries left at the end",
             n_removed, n_rank_err, present);
    if (mismatch_count == 0 && pending == 0)
      $display("kth_remaining_select_remove_tb: clean");
    else
      $display("kth_remaining_select_remove_tb: errors");
    $finish;
  end

endmodule

// ===== kth_remaining_select_remove.f =====
+incdir+sv
sv/ksr_pkg.sv
sv/ksr_in_if.sv
sv/ksr_out_if.sv
sv/kth_remaining_select_remove.sv
sim/order_stat_checker.sv
sim/kth_remaining_select_remove_tb.sv
